/* rtl/bitmap_id_allocator_unit_assert.svh */
// Assertion macros shared by the identifier allocator RTL.
// Each macro expects clk and rst_n to be in scope at the point of use.
`ifndef BITMAP_ID_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_ID_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define BIA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define BIA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/bia_pkg.sv */
// Package for the bitmap identifier allocator: sizes, codes, shared types
// and small bit-search helpers. No dependencies.
`default_nettype none

package bia_pkg;

  // Identifier space and derived sizes
  localparam int NUM_IDS   = 4096;
  localparam int ID_W      = 12;
  localparam int CNT_W     = 13;
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam int ID_WORDS  = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W   = $clog2(ID_WORDS);
  localparam int SCAN_W    = $clog2(ID_WORDS + 1);
  localparam int TAIL_BITS = NUM_IDS % WORD_BITS;

  typedef logic [WORD_BITS-1:0] word_t;

  // Command carried in tuser of the input channel
  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  // Status carried in tuser of the result channel
  typedef enum logic [1:0] {
    ST_ALLOC = 2'd0,
    ST_FULL  = 2'd1,
    ST_REL   = 2'd2
  } status_t;

  // Bitmap memory access request (one read and one write port)
  typedef struct packed {
    logic               rd_en;
    logic [WADDR_W-1:0] rd_addr;
    logic               wr_en;
    logic [WADDR_W-1:0] wr_addr;
    word_t              wr_data;
  } mem_req_t;

  // One result transaction
  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   alloc_index;
    logic [CNT_W-1:0]  in_use;
  } result_t;

  // Bits of a word that stand for real identifiers
  function automatic word_t live_mask(input logic [WADDR_W-1:0] w);
    word_t m;
    m = '1;
    if (TAIL_BITS != 0 && w == WADDR_W'(ID_WORDS - 1)) begin
      m = word_t'((64'd1 << TAIL_BITS) - 64'd1);
    end
    return m;
  endfunction

  // Rotate right by s
  function automatic word_t rotr(input word_t v, input logic [BIT_W-1:0] s);
    word_t r;
    r = (v >> s) | (v << (6'd32 - {1'b0, s}));
    return r;
  endfunction

  // Position of the lowest set bit (zero when none)
  function automatic logic [BIT_W-1:0] first_set(input word_t v);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) pos = BIT_W'(i);
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

/* rtl/bia_bitmap_mem.sv */
// Used-bit bitmap store: synchronous memory, one read and one write port,
// registered read data. Per-word valid flags make unwritten words read as free.
// Depends on bia_pkg.
`default_nettype none

module bia_bitmap_mem (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bia_pkg::mem_req_t req,
  output      bia_pkg::word_t    rd_data
);

  bia_pkg::word_t mem [bia_pkg::ID_WORDS];
  logic [bia_pkg::ID_WORDS-1:0] vld_r;
  bia_pkg::word_t rd_data_r;
  logic           rd_vld_r;

  // Word storage and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  // Written-word flags, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr];
      end
    end
  end

  // Never-written word reads as all free
  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

`default_nettype wire

/* rtl/bia_ctrl.sv */
// Allocation sequencer: takes one command, scans or updates the bitmap
// word by word through the memory port, and hands back one result.
// Depends on bia_pkg.
`default_nettype none

module bia_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output      logic                         in_tready,
  input  wire bia_pkg::cmd_t                in_cmd,
  input  wire logic [bia_pkg::ID_W-1:0]     in_index,
  input  wire logic                         slot_free,
  output      logic                         push,
  output      bia_pkg::result_t             res,
  output      bia_pkg::mem_req_t            mem_req,
  input  wire bia_pkg::word_t               rd_data
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_PUSH  = 3'b100
  } state_t;

  localparam int ID_W    = bia_pkg::ID_W;
  localparam int CNT_W   = bia_pkg::CNT_W;
  localparam int WADDR_W = bia_pkg::WADDR_W;
  localparam int BIT_W   = bia_pkg::BIT_W;
  localparam int SCAN_W  = bia_pkg::SCAN_W;

  state_t                 state_r, state_nxt;
  bia_pkg::cmd_t          cmd_r, cmd_nxt;
  logic [ID_W-1:0]        rel_idx_r, rel_idx_nxt;
  logic [ID_W-1:0]        cursor_r, cursor_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [WADDR_W-1:0]     word_r, word_nxt;
  logic [BIT_W-1:0]       bit_r, bit_nxt;
  logic [SCAN_W-1:0]      scan_r, scan_nxt;
  bia_pkg::result_t       res_r, res_nxt;

  bia_pkg::word_t         avail;
  logic [BIT_W-1:0]       k;
  logic [BIT_W-1:0]       hit_bit;
  logic [ID_W-1:0]        grant;
  logic [CNT_W-1:0]       grant_inc;
  logic [WADDR_W-1:0]     word_inc;
  bia_pkg::word_t         rel_mask;
  logic [CNT_W-1:0]       cnt_dec;

  // Free-bit search in the word just read, starting at the cursor bit
  always_comb begin
    avail     = ~rd_data & bia_pkg::live_mask(word_r);
    k         = bia_pkg::first_set(bia_pkg::rotr(avail, bit_r));
    hit_bit   = bit_r + k;
    grant     = {word_r, hit_bit};
    grant_inc = {1'b0, grant} + 1'b1;
    word_inc  = (word_r == WADDR_W'(bia_pkg::ID_WORDS - 1)) ? '0 : word_r + 1'b1;
    rel_mask  = bia_pkg::word_t'(1) << rel_idx_r[BIT_W-1:0];
    cnt_dec   = (count_r != '0) ? count_r - 1'b1 : count_r;
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    rel_idx_nxt = rel_idx_r;
    cursor_nxt  = cursor_r;
    count_nxt   = count_r;
    word_nxt    = word_r;
    bit_nxt     = bit_r;
    scan_nxt    = scan_r;
    res_nxt     = res_r;
    mem_req     = '0;
    push        = 1'b0;
    in_tready   = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt     = in_cmd;
          rel_idx_nxt = in_index;
          if (in_cmd == bia_pkg::CMD_ALLOC) begin
            if (count_r >= CNT_W'(bia_pkg::NUM_IDS)) begin
              res_nxt   = '{status: bia_pkg::ST_FULL, alloc_index: '0, in_use: count_r};
              state_nxt = S_PUSH;
            end else begin
              word_nxt        = cursor_r[ID_W-1:BIT_W];
              bit_nxt         = cursor_r[BIT_W-1:0];
              scan_nxt        = '0;
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = cursor_r[ID_W-1:BIT_W];
              state_nxt       = S_CHECK;
            end
          end else begin
            if ({1'b0, in_index} < CNT_W'(bia_pkg::NUM_IDS)) begin
              word_nxt        = in_index[ID_W-1:BIT_W];
              bit_nxt         = '0;
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = in_index[ID_W-1:BIT_W];
              state_nxt       = S_CHECK;
            end else begin
              res_nxt   = '{status: bia_pkg::ST_REL, alloc_index: '0, in_use: count_r};
              state_nxt = S_PUSH;
            end
          end
        end
      end

      S_CHECK: begin
        if (cmd_r == bia_pkg::CMD_ALLOC) begin
          if (avail != '0) begin
            // take the bit, update cursor and count
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = word_r;
            mem_req.wr_data = rd_data | (bia_pkg::word_t'(1) << hit_bit);
            count_nxt       = count_r + 1'b1;
            cursor_nxt      = (grant_inc >= CNT_W'(bia_pkg::NUM_IDS)) ? '0
                                                                     : grant_inc[ID_W-1:0];
            res_nxt   = '{status: bia_pkg::ST_ALLOC, alloc_index: grant,
                          in_use: count_r + 1'b1};
            state_nxt = S_PUSH;
          end else if (scan_r == SCAN_W'(bia_pkg::ID_WORDS)) begin
            res_nxt   = '{status: bia_pkg::ST_FULL, alloc_index: '0, in_use: count_r};
            state_nxt = S_PUSH;
          end else begin
            // full word: move on, wrapping round the space
            word_nxt        = word_inc;
            bit_nxt         = '0;
            scan_nxt        = scan_r + 1'b1;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = word_inc;
          end
        end else begin
          if ((rd_data & rel_mask) != '0) begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = word_r;
            mem_req.wr_data = rd_data & ~rel_mask;
            count_nxt       = cnt_dec;
            res_nxt   = '{status: bia_pkg::ST_REL, alloc_index: '0, in_use: cnt_dec};
          end else begin
            res_nxt   = '{status: bia_pkg::ST_REL, alloc_index: '0, in_use: count_r};
          end
          state_nxt = S_PUSH;
        end
      end

      S_PUSH: begin
        if (slot_free) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cursor_r <= '0;
      count_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      count_r  <= count_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    rel_idx_r <= rel_idx_nxt;
    word_r    <= word_nxt;
    bit_r     <= bit_nxt;
    scan_r    <= scan_nxt;
    res_r     <= res_nxt;
  end

  assign res = res_r;

endmodule

`default_nettype wire

/* rtl/bitmap_id_allocator_unit.sv */
// Top level of the bitmap identifier allocator: stream ports, result
// register, sequencer and bitmap memory. Depends on bia_pkg, bia_ctrl,
// bia_bitmap_mem and the assertion macro header.
//
// Hands out and takes back identifiers 0..4095, tracked one bit each in a
// 128 x 32 bitmap memory. tuser on the input picks allocate or release;
// every command gives exactly one result transaction. A release reads its
// bitmap word and clears the bit, if set, as its result is registered; a
// refused allocation registers its result at once; and an allocation
// reads bitmap words until it finds a free bit. A free bit is always found
// within 128 word reads, since the scan starts at the next-fit cursor and
// reads one word per cycle through the single read port. The next command
// can be taken once the result is pushed to the output register, which
// waits while that register is full and not being drained. One command is
// worked at a time; the result sits in an output register, so the next
// command is accepted while it waits.
// Bitmap words carry written flags cleared by reset, so the block is ready
// as soon as reset is released, with no clearing pass.
`default_nettype none

`include "bitmap_id_allocator_unit_assert.svh"

module bitmap_id_allocator_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [15:0] in_tdata,   // [11:0] release_index, rest zero
  input  wire logic        in_tuser,   // [0] cmd
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [31:0] out_tdata,  // [11:0] alloc_index, [24:12] in_use
  output      logic [1:0]  out_tuser   // [1:0] status
);

  bia_pkg::mem_req_t mem_req;
  bia_pkg::word_t    rd_data;
  bia_pkg::result_t  res;
  logic              push;
  logic              slot_free;
  logic              out_valid_r;
  bia_pkg::result_t  out_res_r;

  // Output slot is free when empty or being drained this cycle
  assign slot_free = !out_valid_r || out_tready;

  bia_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (bia_pkg::cmd_t'(in_tuser)),
    .in_index  (in_tdata[bia_pkg::ID_W-1:0]),
    .slot_free (slot_free),
    .push      (push),
    .res       (res),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  bia_bitmap_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {7'b0, out_res_r.in_use, out_res_r.alloc_index};

  // Checks
  `BIA_ASSERT_NOW(a_push_no_overwrite, push, slot_free, "result pushed into a busy output slot")
  `BIA_ASSERT_NOW(a_no_rw_same_word, mem_req.wr_en && mem_req.rd_en, mem_req.wr_addr != mem_req.rd_addr, "bitmap read and write hit the same word")
  `BIA_ASSERT_NOW(a_count_bound, out_tvalid, out_res_r.in_use <= 13'(bia_pkg::NUM_IDS), "in-use count beyond identifier space")
  `BIA_ASSERT_NOW(a_index_zero, out_tvalid && out_res_r.status != bia_pkg::ST_ALLOC, out_res_r.alloc_index == '0, "index set on a result that grants nothing")
  `BIA_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "second command taken while one is in flight")

endmodule

`default_nettype wire
